// ===== hw/rtl/lfucl_pkg.sv =====
// Shared types and constants of the LFU cache with LRU tie break.
package lfucl_pkg;

  localparam int CFG_W = 5;
  localparam int WORD_W = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
  localparam logic [WORD_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic signed [WORD_W-1:0] MISS_VALUE = -32'sd1;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [WORD_W-1:0] key;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] read_value;
    logic                     evicted;
    logic signed [WORD_W-1:0] evicted_key;
  } out_word_t;

  typedef logic [CFG_W-1:0] cfg_word_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic key_eq;
    logic cnt_lt;
    logic cnt_eq;
    logic rank_gt;
    logic rank_lt;
  } cmp_res_t;

endpackage

// ===== hw/rtl/lfucl_chan_if.sv =====
// Valid/ready channel that carries one word of a given payload type.
interface lfucl_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/lfucl_entry_ram.sv =====
// Entry store: key, value, use count and recency rank, one read and one write port.
module lfucl_entry_ram #(
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
  output logic [lfucl_pkg::WORD_W-1:0]                   rd_key,
  output logic [lfucl_pkg::WORD_W-1:0]                   rd_val,
  output logic [lfucl_pkg::WORD_W-1:0]                   rd_cnt,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_rank,
  input  logic                                           wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
  input  logic [lfucl_pkg::WORD_W-1:0]                   wr_key,
  input  logic [lfucl_pkg::WORD_W-1:0]                   wr_val,
  input  logic [lfucl_pkg::WORD_W-1:0]                   wr_cnt,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_rank
);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [lfucl_pkg::WORD_W-1:0] key_mem  [DEPTH];
  logic [lfucl_pkg::WORD_W-1:0] val_mem  [DEPTH];
  logic [lfucl_pkg::WORD_W-1:0] cnt_mem  [DEPTH];
  logic [IDX_W-1:0]             rank_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      val_mem[wr_addr]  <= wr_val;
      cnt_mem[wr_addr]  <= wr_cnt;
      rank_mem[wr_addr] <= wr_rank;
    end
    rd_key  <= key_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
    rd_cnt  <= cnt_mem[rd_addr];
    rd_rank <= rank_mem[rd_addr];
  end
endmodule

// ===== hw/rtl/lfucl_cmp_unit.sv =====
// Shared compare unit: key match, count and rank order of one entry against references.
module lfucl_cmp_unit #(
  parameter int RANK_W = 4
) (
  input  logic [lfucl_pkg::WORD_W-1:0] ent_key,
  input  logic [lfucl_pkg::WORD_W-1:0] ref_key,
  input  logic [lfucl_pkg::WORD_W-1:0] ent_cnt,
  input  logic [lfucl_pkg::WORD_W-1:0] ref_cnt,
  input  logic [RANK_W-1:0]            ent_rank,
  input  logic [RANK_W-1:0]            ref_rank,
  output lfucl_pkg::cmp_res_t          res
);
  always_comb begin
    res.key_eq  = (ent_key == ref_key);
    res.cnt_lt  = (ent_cnt < ref_cnt);
    res.cnt_eq  = (ent_cnt == ref_cnt);
    res.rank_gt = (ent_rank > ref_rank);
    res.rank_lt = (ent_rank < ref_rank);
  end
endmodule

// ===== hw/rtl/lfu_cache_lru_tiebreak.sv =====
// Top level: LFU cache with LRU tie break, sequencer around one entry store and compare unit.
// A hit or a put runs a scan sweep, a decision state and an update sweep before the final state;
//   a get that misses skips the update sweep; capacity zero goes straight to the final state.
// One word at a time: the next word can be taken in the cycle after the result is
//   loaded into the output register. Both sweeps walk the entry store's one read port.
// Reset (rst_n low, synchronous): all entries invalid, capacity back to 16, output empty.
module lfu_cache_lru_tiebreak #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  lfucl_chan_if.sink   in_chan,
  lfucl_chan_if.source out_chan,
  lfucl_chan_if.sink   cfg_chan
);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CAPW  = (CNT_W > lfucl_pkg::CFG_W) ? CNT_W : lfucl_pkg::CFG_W;
  localparam int WW    = lfucl_pkg::WORD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [lfucl_pkg::CFG_W-1:0] cap_r;
  logic [CAPACITY-1:0]         valid_r;

  // Latched word
  logic                        kind_r;
  logic [WW-1:0]               key_r;
  logic [WW-1:0]               val_r;

  // Sweep address and the pipeline tag that travels with the read data
  logic [IDX_W-1:0]            rd_idx_r;
  logic                        issue_r;
  logic                        pv_r;
  logic [IDX_W-1:0]            pidx_r;

  // Scan results
  logic [CNT_W-1:0]            occ_r;
  logic                        found_r;
  logic [IDX_W-1:0]            slot_r;
  logic [WW-1:0]               hit_val_r;
  logic [WW-1:0]               hit_cnt_r;
  logic [IDX_W-1:0]            hit_rank_r;
  logic                        free_found_r;
  logic [IDX_W-1:0]            free_r;
  logic                        best_found_r;
  logic [IDX_W-1:0]            best_r;
  logic [WW-1:0]               best_cnt_r;
  logic [IDX_W-1:0]            best_rank_r;
  logic [WW-1:0]               best_key_r;

  // Update pass controls
  logic                        all_inc_r;
  logic [WW-1:0]               new_val_r;
  logic [WW-1:0]               new_cnt_r;

  lfucl_pkg::out_word_t        res_r;
  lfucl_pkg::out_word_t        out_data_r;
  logic                        out_valid_r;

  // Entry store ports
  logic [WW-1:0]               rd_key, rd_val, rd_cnt;
  logic [IDX_W-1:0]            rd_rank;
  logic                        wr_en;
  logic [WW-1:0]               wr_key, wr_val, wr_cnt;
  logic [IDX_W-1:0]            wr_rank;

  lfucl_pkg::cmp_res_t         cmp;

  logic [CAPW-1:0]             cap_ext, cap_eff;
  logic                        evict_need;
  logic                        ent_valid;
  logic                        is_last;
  logic                        better;
  logic [WW-1:0]               hit_cnt_inc;
  logic                        in_fire, out_fire;

  lfucl_entry_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .rd_addr(rd_idx_r),
    .rd_key (rd_key),
    .rd_val (rd_val),
    .rd_cnt (rd_cnt),
    .rd_rank(rd_rank),
    .wr_en  (wr_en),
    .wr_addr(pidx_r),
    .wr_key (wr_key),
    .wr_val (wr_val),
    .wr_cnt (wr_cnt),
    .wr_rank(wr_rank)
  );

  // One compare unit serves both sweeps: victim search while scanning,
  // rank shift while updating (best_rank_r then holds the touched rank).
  lfucl_cmp_unit #(
    .RANK_W(IDX_W)
  ) u_cmp (
    .ent_key (rd_key),
    .ref_key (key_r),
    .ent_cnt (rd_cnt),
    .ref_cnt (best_cnt_r),
    .ent_rank(rd_rank),
    .ref_rank(best_rank_r),
    .res     (cmp)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;

  always_comb begin
    // Clamp the capacity register to the number of slots built.
    cap_ext     = CAPW'(cap_r);
    cap_eff     = (cap_ext > CAPW'(CAPACITY)) ? CAPW'(CAPACITY) : cap_ext;
    evict_need  = (CAPW'(occ_r) >= cap_eff);
    ent_valid   = valid_r[pidx_r];
    is_last     = pv_r && (pidx_r == LAST_IDX);
    // Lower count wins; on equal counts the older entry (higher rank) wins.
    better      = !best_found_r || cmp.cnt_lt || (cmp.cnt_eq && cmp.rank_gt);
    hit_cnt_inc = (hit_cnt_r == lfucl_pkg::COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 32'd1;
  end

  // Update pass write-back: the target slot gets the new entry at rank 0; every other live
  // entry more recent than the touched one ages by one (every live one on a fill with room).
  always_comb begin
    wr_en   = 1'b0;
    wr_key  = rd_key;
    wr_val  = rd_val;
    wr_cnt  = rd_cnt;
    wr_rank = rd_rank + IDX_W'(1);
    if (state_r == S_UPD && pv_r) begin
      if (pidx_r == slot_r) begin
        wr_en   = 1'b1;
        wr_key  = key_r;
        wr_val  = new_val_r;
        wr_cnt  = new_cnt_r;
        wr_rank = '0;
      end else if (ent_valid && (all_inc_r || cmp.rank_lt)) begin
        wr_en = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (cap_eff == '0) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (is_last) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = (!found_r && kind_r == lfucl_pkg::KIND_GET) ? S_FIN : S_UPD;
      end
      S_UPD: begin
        if (is_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= lfucl_pkg::CAP_RESET;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_chan.valid) begin
        cap_r <= cfg_chan.data;
      end

      // Advance the sweep address; the read data returns in the next cycle.
      pv_r   <= issue_r;
      pidx_r <= rd_idx_r;
      if (issue_r) begin
        if (rd_idx_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end

      // Drop the output word once taken, unless a new one is loaded below.
      if (out_fire && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r       <= in_chan.data.kind;
            key_r        <= in_chan.data.key;
            val_r        <= in_chan.data.value;
            occ_r        <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            best_found_r <= 1'b0;
            rd_idx_r     <= '0;
            // Disabled cache: answer a miss and store nothing.
            res_r.hit         <= 1'b0;
            res_r.read_value  <= (in_chan.data.kind == lfucl_pkg::KIND_GET) ?
                                 lfucl_pkg::MISS_VALUE : '0;
            res_r.evicted     <= 1'b0;
            res_r.evicted_key <= '0;
            issue_r           <= (cap_eff != '0);
          end
        end
        S_SCAN: begin
          if (pv_r) begin
            if (ent_valid) begin
              occ_r <= occ_r + CNT_W'(1);
              if (cmp.key_eq && !found_r) begin
                found_r    <= 1'b1;
                slot_r     <= pidx_r;
                hit_val_r  <= rd_val;
                hit_cnt_r  <= rd_cnt;
                hit_rank_r <= rd_rank;
              end
              if (better) begin
                best_found_r <= 1'b1;
                best_r       <= pidx_r;
                best_cnt_r   <= rd_cnt;
                best_rank_r  <= rd_rank;
                best_key_r   <= rd_key;
              end
            end else if (!free_found_r) begin
              free_found_r <= 1'b1;
              free_r       <= pidx_r;
            end
          end
        end
        S_DEC: begin
          rd_idx_r  <= '0;
          all_inc_r <= 1'b0;
          new_val_r <= val_r;
          new_cnt_r <= 32'd1;
          if (found_r) begin
            // Hit: refresh the entry and bump its count.
            res_r.hit        <= 1'b1;
            res_r.read_value <= (kind_r == lfucl_pkg::KIND_GET) ? hit_val_r : '0;
            new_val_r        <= (kind_r == lfucl_pkg::KIND_PUT) ? val_r : hit_val_r;
            new_cnt_r        <= hit_cnt_inc;
            best_rank_r      <= hit_rank_r;
            issue_r          <= 1'b1;
          end else if (kind_r == lfucl_pkg::KIND_GET) begin
            res_r.read_value <= lfucl_pkg::MISS_VALUE;
          end else if (evict_need) begin
            // Full: reuse the victim's slot; ranks shift exactly as for a touch.
            res_r.evicted     <= 1'b1;
            res_r.evicted_key <= best_key_r;
            slot_r            <= best_r;
            issue_r           <= 1'b1;
          end else begin
            // Room left: fill the first free slot and age every live entry.
            slot_r    <= free_r;
            all_inc_r <= 1'b1;
            issue_r   <= 1'b1;
          end
        end
        S_UPD: begin
          if (is_last) begin
            valid_r[slot_r] <= 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The read pipeline only runs during the two sweeps.
  a_sweep_only: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_SCAN || state_r == S_UPD))
    else $error("read data tagged valid outside a sweep");

  // An insert without eviction must have found an empty slot.
  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC && !found_r && kind_r == lfucl_pkg::KIND_PUT && !evict_need)
      |-> free_found_r)
    else $error("insert with room but no free slot seen");

  // After the update pass the target slot holds a live entry.
  a_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && is_last) |=> valid_r[slot_r])
    else $error("updated slot not marked valid");

  // A result is only loaded from the final state.
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("output loaded outside the final state");

endmodule
